[rtl/ckh_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the canonical k-mer histogram block.
// Used by every module under rtl/; depends on nothing else.
package ckh_pkg;

  // Default configuration handed down from the top level.
  localparam int KMER_LEN_DEF   = 6;
  localparam int COUNT_BITS_DEF = 24;

  // Fixed port widths.
  localparam int CHAR_BITS      = 8;
  localparam int IDX_BITS       = 12;
  localparam int OUT_COUNT_BITS = 24;

  // Histogram clearing is done by epoch marks; a full sweep runs when the mark wraps.
  localparam int EPOCH_BITS = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // What the back end has to do with one request.
  typedef enum logic [1:0] {
    CMD_PASS       = 2'd0,
    CMD_COUNT      = 2'd1,
    CMD_READ       = 2'd2,
    CMD_READ_EMPTY = 2'd3
  } cmd_kind_t;

  // Classified request travelling from front to back.
  typedef struct packed {
    cmd_kind_t             kind;
    logic                  bad;
    logic                  sweep;
    logic [EPOCH_BITS-1:0] epoch;
    logic [IDX_BITS-1:0]   idx;
  } cmd_t;

endpackage

[rtl/ckh_canon.sv]
`timescale 1ns / 1ps
// Canonical form of a k-mer: minimum over all rotations of it and of its reverse complement.
// Depends on ckh_pkg only through the default parameter value.
module ckh_canon #(
  parameter int KMER_LEN = ckh_pkg::KMER_LEN_DEF
) (
  input  logic [2*KMER_LEN-1:0] kmer,
  output logic [2*KMER_LEN-1:0] canon
);

  localparam int KBITS  = 2 * KMER_LEN;
  localparam int NCAND  = 2 * KMER_LEN;
  localparam int LEVELS = $clog2(NCAND);
  localparam int NPAD   = 1 << LEVELS;

  logic [KBITS-1:0] rc;
  logic [KBITS-1:0] cand [NCAND];
  logic [KBITS-1:0] tree [LEVELS+1][NPAD];

  // Reverse complement: invert every base and reverse the base order.
  always_comb begin
    for (int i = 0; i < KMER_LEN; i++) begin
      rc[2*(KMER_LEN-1-i) +: 2] = ~kmer[2*i +: 2];
    end
  end

  // All cyclic rotations by whole bases, of the k-mer and of its reverse complement.
  always_comb begin
    for (int i = 0; i < KMER_LEN; i++) begin
      cand[i]            = (kmer >> (2*i)) | (kmer << (KBITS - 2*i));
      cand[KMER_LEN + i] = (rc >> (2*i)) | (rc << (KBITS - 2*i));
    end
  end

  // Balanced minimum tree; unused leaves hold the largest value.
  always_comb begin
    for (int j = 0; j < NPAD; j++) begin
      tree[0][j] = (j < NCAND) ? cand[j] : '1;
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < NPAD; j++) begin
        if (j < (NPAD >> (l + 1))) begin
          tree[l+1][j] = (tree[l][2*j] < tree[l][2*j+1]) ? tree[l][2*j] : tree[l][2*j+1];
        end else begin
          tree[l+1][j] = '1;
        end
      end
    end
  end

  assign canon = tree[LEVELS][0];

endmodule

[rtl/ckh_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, decodes bases, keeps the rolling window and classifies.
// Depends on ckh_pkg and ckh_canon.
module ckh_front #(
  parameter int KMER_LEN = ckh_pkg::KMER_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [ckh_pkg::CHAR_BITS-1:0]   base_char,
  input  logic                            first,
  input  logic [ckh_pkg::IDX_BITS-1:0]    read_index,
  input  logic                            q_full,
  input  logic                            back_busy,
  output logic                            q_push,
  output ckh_pkg::cmd_t                   q_cmd,
  output logic [2*KMER_LEN-1:0]           q_addr
);

  localparam int KBITS     = 2 * KMER_LEN;
  localparam int SEEN_BITS = $clog2(KMER_LEN + 1);
  localparam logic [SEEN_BITS-1:0] SEEN_FULL = SEEN_BITS'(KMER_LEN);
  localparam int RANGE_BITS = ckh_pkg::IDX_BITS + 21;
  localparam logic [RANGE_BITS-1:0] HIST_SIZE = RANGE_BITS'(1) << KBITS;

  localparam logic [ckh_pkg::CHAR_BITS-1:0] CHAR_A = 8'h41;
  localparam logic [ckh_pkg::CHAR_BITS-1:0] CHAR_C = 8'h43;
  localparam logic [ckh_pkg::CHAR_BITS-1:0] CHAR_G = 8'h47;
  localparam logic [ckh_pkg::CHAR_BITS-1:0] CHAR_T = 8'h54;

  logic [KBITS-1:0]                 window;
  logic [KBITS-1:0]                 window_next;
  logic [SEEN_BITS-1:0]             seen;
  logic [SEEN_BITS-1:0]             seen_next;
  logic [ckh_pkg::EPOCH_BITS-1:0]   epoch;
  logic [ckh_pkg::EPOCH_BITS-1:0]   epoch_next;

  logic                             a_valid;
  ckh_pkg::cmd_kind_t               a_kind;
  logic                             a_bad;
  logic                             a_sweep;
  logic [ckh_pkg::EPOCH_BITS-1:0]   a_epoch;
  logic [KBITS-1:0]                 a_window;
  logic [ckh_pkg::IDX_BITS-1:0]     a_ridx;

  logic                             accept;
  logic                             push;
  logic                             new_str;
  logic [1:0]                       code;
  logic                             char_ok;
  logic [KBITS-1:0]                 win_base;
  logic [SEEN_BITS-1:0]             seen_base;
  logic                             sweep_flag;
  ckh_pkg::cmd_kind_t               kind;
  logic [KBITS-1:0]                 canon;

  // Base decoder.
  always_comb begin
    unique case (base_char)
      CHAR_A:  begin code = 2'd0; char_ok = 1'b1; end
      CHAR_C:  begin code = 2'd1; char_ok = 1'b1; end
      CHAR_G:  begin code = 2'd2; char_ok = 1'b1; end
      CHAR_T:  begin code = 2'd3; char_ok = 1'b1; end
      default: begin code = 2'd0; char_ok = 1'b0; end
    endcase
  end

  // Handshake: the holding register empties into the queue whenever there is room.
  assign q_push   = a_valid && !q_full;
  assign in_stall = (a_valid && q_full) || back_busy;
  assign accept   = in_valid && !in_stall;
  assign push     = !operation;
  assign new_str  = push && first;

  // Window, fill level and epoch after this request.
  always_comb begin
    win_base   = new_str ? '0 : window;
    seen_base  = new_str ? '0 : seen;
    epoch_next = epoch;
    sweep_flag = 1'b0;
    if (new_str) begin
      if (epoch == ckh_pkg::EPOCH_LAST) begin
        epoch_next = ckh_pkg::EPOCH_FIRST;
        sweep_flag = 1'b1;
      end else begin
        epoch_next = epoch + 1'b1;
      end
    end
    window_next = char_ok ? KBITS'({win_base, code}) : win_base;
    seen_next   = (char_ok && seen_base != SEEN_FULL) ? seen_base + 1'b1 : seen_base;
  end

  // Classification of the request.
  always_comb begin
    if (operation) begin
      kind = ({21'b0, read_index} < HIST_SIZE) ? ckh_pkg::CMD_READ : ckh_pkg::CMD_READ_EMPTY;
    end else if (char_ok && seen_next == SEEN_FULL) begin
      kind = ckh_pkg::CMD_COUNT;
    end else begin
      kind = ckh_pkg::CMD_PASS;
    end
  end

  // String state, updated by pushes only.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      seen   <= '0;
      epoch  <= ckh_pkg::EPOCH_FIRST;
    end else if (accept && push) begin
      window <= window_next;
      seen   <= seen_next;
      epoch  <= epoch_next;
    end
  end

  // Holding register in front of the canonical-form logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (q_push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind   <= kind;
      a_bad    <= push && !char_ok;
      a_sweep  <= push && sweep_flag;
      a_epoch  <= push ? epoch_next : epoch;
      a_window <= window_next;
      a_ridx   <= read_index;
    end
  end

  ckh_canon #(
    .KMER_LEN (KMER_LEN)
  ) u_canon (
    .kmer  (a_window),
    .canon (canon)
  );

  // Build the queued request.
  always_comb begin
    q_cmd.kind  = a_kind;
    q_cmd.bad   = a_bad;
    q_cmd.sweep = a_sweep;
    q_cmd.epoch = a_epoch;
    if (a_kind == ckh_pkg::CMD_COUNT) begin
      q_cmd.idx = ckh_pkg::IDX_BITS'(canon);
      q_addr    = canon;
    end else begin
      q_cmd.idx = a_ridx;
      q_addr    = KBITS'(a_ridx);
    end
  end

endmodule

[rtl/ckh_queue.sv]
`timescale 1ns / 1ps
// Short request queue between the front and back ends.
// Depends on ckh_pkg for the request type and depth.
module ckh_queue #(
  parameter int ADDR_BITS = 2 * ckh_pkg::KMER_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ckh_pkg::cmd_t        push_cmd,
  input  logic [ADDR_BITS-1:0] push_addr,
  output logic                 full,
  input  logic                 pop,
  output ckh_pkg::cmd_t        head_cmd,
  output logic [ADDR_BITS-1:0] head_addr,
  output logic                 nonempty
);

  localparam int DEPTH    = ckh_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam logic [PTR_BITS:0] FILL_MAX = (PTR_BITS + 1)'(DEPTH);

  ckh_pkg::cmd_t        cmd_q  [DEPTH];
  logic [ADDR_BITS-1:0] addr_q [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [PTR_BITS:0]    fill;
  logic [PTR_BITS:0]    fill_next;

  assign full      = (fill == FILL_MAX);
  assign nonempty  = (fill != '0);
  assign head_cmd  = cmd_q[rd_ptr];
  assign head_addr = addr_q[rd_ptr];

  // Fill level follows pushes and pops.
  always_comb begin
    case ({push, pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr]  <= push_cmd;
      addr_q[wr_ptr] <= push_addr;
    end
  end

endmodule

[rtl/ckh_back.sv]
`timescale 1ns / 1ps
// Back end: histogram memory, read-modify-write pipeline, clearing sweep and result register.
// Depends on ckh_pkg.
module ckh_back #(
  parameter int KMER_LEN   = ckh_pkg::KMER_LEN_DEF,
  parameter int COUNT_BITS = ckh_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_nonempty,
  input  ckh_pkg::cmd_t                      head_cmd,
  input  logic [2*KMER_LEN-1:0]              head_addr,
  output logic                               q_pop,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kmer_valid,
  output logic [ckh_pkg::IDX_BITS-1:0]       canonical_index,
  output logic [ckh_pkg::OUT_COUNT_BITS-1:0] count,
  output logic                               bad_char
);

  localparam int KBITS     = 2 * KMER_LEN;
  localparam int HIST_SIZE = 1 << KBITS;
  localparam int WORD_BITS = ckh_pkg::EPOCH_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } back_state_t;

  back_state_t                     state;
  back_state_t                     state_next;
  logic [KBITS-1:0]                sweep_addr;
  logic [KBITS-1:0]                sweep_addr_next;
  logic                            sweep_start;
  logic                            sweep_end;
  logic                            sweep_own;
  logic                            swept;

  logic [WORD_BITS-1:0]            mem [HIST_SIZE];
  logic                            mem_we;
  logic [KBITS-1:0]                mem_wa;
  logic [WORD_BITS-1:0]            mem_wd;
  logic [WORD_BITS-1:0]            rd_data;

  logic                            s2_valid;
  ckh_pkg::cmd_t                   s2_cmd;
  logic [KBITS-1:0]                s2_addr;
  logic                            adv2;

  logic                            last_wr_valid;
  logic [KBITS-1:0]                last_wr_addr;
  logic [WORD_BITS-1:0]            last_wr_data;

  logic [WORD_BITS-1:0]            stored;
  logic [COUNT_BITS-1:0]           cnt_old;
  logic [COUNT_BITS-1:0]           cnt_new;
  logic [COUNT_BITS-1:0]           cnt_res;
  logic                            res_kv;

  // Clearing sweep sequencer: runs after reset and when the epoch mark wraps.
  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    sweep_start     = 1'b0;
    sweep_end       = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (q_nonempty && head_cmd.sweep && !swept && !s2_valid) begin
          state_next      = ST_SWEEP;
          sweep_addr_next = '0;
          sweep_start     = 1'b1;
        end
      end
      ST_SWEEP: begin
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == '1) begin
          state_next = ST_RUN;
          sweep_end  = 1'b1;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  assign busy = (state == ST_SWEEP);

  // Pipeline advance: the second stage moves into the result register when it is free.
  assign adv2  = s2_valid && (!out_valid || !out_stall);
  assign q_pop = q_nonempty && (state == ST_RUN) && (!head_cmd.sweep || swept)
                 && (!s2_valid || adv2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      sweep_own  <= 1'b0;
      swept      <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      if (sweep_start) begin
        sweep_own <= 1'b1;
      end else if (sweep_end) begin
        sweep_own <= 1'b0;
      end
      if (sweep_end && sweep_own) begin
        swept <= 1'b1;
      end else if (q_pop) begin
        swept <= 1'b0;
      end
    end
  end

  // Current stored word, with the latest write forwarded over the registered read.
  always_comb begin
    if (last_wr_valid && last_wr_addr == s2_addr) begin
      stored = last_wr_data;
    end else begin
      stored = rd_data;
    end
    if (stored[WORD_BITS-1 -: ckh_pkg::EPOCH_BITS] == s2_cmd.epoch) begin
      cnt_old = stored[COUNT_BITS-1:0];
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
  end

  // Result selection.
  always_comb begin
    case (s2_cmd.kind)
      ckh_pkg::CMD_COUNT: cnt_res = cnt_new;
      ckh_pkg::CMD_READ:  cnt_res = cnt_old;
      default:            cnt_res = '0;
    endcase
    res_kv = (s2_cmd.kind != ckh_pkg::CMD_PASS);
  end

  // Single write port shared by the sweep and the count update.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = s2_addr;
    mem_wd = {s2_cmd.epoch, cnt_new};
    if (state == ST_SWEEP) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr;
      mem_wd = '0;
    end else if (adv2 && s2_cmd.kind == ckh_pkg::CMD_COUNT) begin
      mem_we = 1'b1;
    end
  end

  // Histogram memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data <= mem[head_addr];
    end
  end

  // Stage two control and forwarding record.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid      <= 1'b0;
      last_wr_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s2_valid <= 1'b1;
      end else if (adv2) begin
        s2_valid <= 1'b0;
      end
      if (state == ST_SWEEP) begin
        last_wr_valid <= 1'b0;
      end else if (mem_we) begin
        last_wr_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cmd  <= head_cmd;
      s2_addr <= head_addr;
    end
    if (mem_we && state == ST_RUN) begin
      last_wr_addr <= mem_wa;
      last_wr_data <= mem_wd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      kmer_valid      <= res_kv;
      canonical_index <= res_kv ? s2_cmd.idx : '0;
      count           <= ckh_pkg::OUT_COUNT_BITS'(cnt_res);
      bad_char        <= s2_cmd.bad;
    end
  end

`ifndef SYNTH
  a_sweep_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !s2_valid)
    else $error("sweep running while a request is in the update stage");

  a_pop_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (q_pop && head_cmd.sweep) |-> swept)
    else $error("request that needs a sweep left the queue unswept");

  a_swept_pending: assert property (@(posedge clk) disable iff (rst)
    swept |-> (q_nonempty && head_cmd.sweep))
    else $error("sweep marked done with no request waiting for it");

  a_forward_record: assert property (@(posedge clk) disable iff (rst)
    (adv2 && s2_cmd.kind == ckh_pkg::CMD_COUNT) |=>
      (last_wr_valid && last_wr_addr == $past(s2_addr)))
    else $error("count update not recorded for forwarding");
`endif

endmodule

[rtl/canonical_kmer_histogram_unit.sv]
`timescale 1ns / 1ps
// Canonical k-mer histogram: top level joining front end, queue and back end.
// Depends on ckh_pkg, ckh_front, ckh_canon, ckh_queue and ckh_back.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request per accepted edge:
//   a base push (operation = 0, base_char, first) or a count read (operation = 1,
//   read_index). Every request gives exactly one result on the output channel
//   (out_valid / out_stall) with kmer_valid, canonical_index, count and bad_char.
//   Throughput is one request per cycle while in_stall is low; a result passes
//   through the holding register, the queue and the memory read, then waits in the
//   result register until taken.
//   The histogram lives in one memory of 4^KMER_LEN words with a registered read;
//   back-to-back updates of one entry are forwarded around that read.
//   A new string does not clear the memory; it moves to a new epoch mark instead.
//   After reset, and on every 255th new string when the mark wraps, the back end
//   sweeps the whole memory, one entry per cycle, and in_stall is high while it runs.
//   When the receiver stalls, the result register holds, the four-entry queue
//   fills, and in_stall rises once both the queue and the holding register are full.
module canonical_kmer_histogram_unit #(
  parameter int KMER_LEN   = ckh_pkg::KMER_LEN_DEF,
  parameter int COUNT_BITS = ckh_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [ckh_pkg::CHAR_BITS-1:0]      base_char,
  input  logic                               first,
  input  logic [ckh_pkg::IDX_BITS-1:0]       read_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kmer_valid,
  output logic [ckh_pkg::IDX_BITS-1:0]       canonical_index,
  output logic [ckh_pkg::OUT_COUNT_BITS-1:0] count,
  output logic                               bad_char
);

  localparam int KBITS = 2 * KMER_LEN;

  logic             q_full;
  logic             q_push;
  ckh_pkg::cmd_t    q_cmd;
  logic [KBITS-1:0] q_addr;
  logic             q_pop;
  logic             q_nonempty;
  ckh_pkg::cmd_t    head_cmd;
  logic [KBITS-1:0] head_addr;
  logic             back_busy;

  // Request intake and classification.
  ckh_front #(
    .KMER_LEN (KMER_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .base_char  (base_char),
    .first      (first),
    .read_index (read_index),
    .q_full     (q_full),
    .back_busy  (back_busy),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .q_addr     (q_addr)
  );

  // Decoupling queue.
  ckh_queue #(
    .ADDR_BITS (KBITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .push_addr (q_addr),
    .full      (q_full),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .head_addr (head_addr),
    .nonempty  (q_nonempty)
  );

  // Histogram update and results.
  ckh_back #(
    .KMER_LEN   (KMER_LEN),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_nonempty      (q_nonempty),
    .head_cmd        (head_cmd),
    .head_addr       (head_addr),
    .q_pop           (q_pop),
    .busy            (back_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kmer_valid      (kmer_valid),
    .canonical_index (canonical_index),
    .count           (count),
    .bad_char        (bad_char)
  );

endmodule

[test/ckh_tb_pkg.sv]
`timescale 1ns / 1ps
// Testbench-side codes for the canonical k-mer histogram: request operations and base characters.
// Shared by kmer_tally_checker and tb_top; depends on nothing else.
package ckh_tb_pkg;

  // Request operations.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // The only characters that the block accepts as bases.
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

endpackage

[test/kmer_tally_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of canonical_kmer_histogram_unit, predicts each result and compares it.
// Depends on ckh_pkg for widths and on ckh_tb_pkg for operation and character codes.
module kmer_tally_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               operation,
  input  logic [ckh_pkg::CHAR_BITS-1:0]      base_char,
  input  logic                               first,
  input  logic [ckh_pkg::IDX_BITS-1:0]       read_index,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               kmer_valid,
  input  logic [ckh_pkg::IDX_BITS-1:0]       canonical_index,
  input  logic [ckh_pkg::OUT_COUNT_BITS-1:0] count,
  input  logic                               bad_char,
  output int                                 error_count,
  output int                                 pending_results
);

  localparam int KMER_LEN = ckh_pkg::KMER_LEN_DEF;
  localparam int KBITS    = 2 * KMER_LEN;
  localparam longint unsigned SLOTS     = 64'd1 << KBITS;
  localparam longint unsigned COUNT_TOP = (64'd1 << ckh_pkg::COUNT_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic                               kmer_valid;
    logic [ckh_pkg::IDX_BITS-1:0]       index;
    logic [ckh_pkg::OUT_COUNT_BITS-1:0] count;
    logic                               bad;
  } kmer_result_t;

  // Predicted state of the block: base window, bases held and the count table.
  logic [KBITS-1:0] window_q;
  int unsigned      bases_held;
  longint unsigned  kmer_tally [longint unsigned];
  kmer_result_t     awaited_results [$];
  int               errs;

  // Rotates the k-mer right by one base.
  function automatic logic [KBITS-1:0] rotate_base(input logic [KBITS-1:0] v);
    return {v[1:0], v[KBITS-1:2]};
  endfunction

  function automatic logic [KBITS-1:0] least_rotation(input logic [KBITS-1:0] v);
    logic [KBITS-1:0] best;
    best = v;
    for (int i = 0; i < KMER_LEN; i++) begin
      v = rotate_base(v);
      if (v < best) best = v;
    end
    return best;
  endfunction

  // Complements every base and reverses their order.
  function automatic logic [KBITS-1:0] flip_strand(input logic [KBITS-1:0] v);
    logic [KBITS-1:0] inv;
    logic [KBITS-1:0] r;
    inv = ~v;
    r = '0;
    for (int i = 0; i < KMER_LEN; i++) r = (r << 2) | KBITS'(inv[2*i +: 2]);
    return r;
  endfunction

  function automatic logic [KBITS-1:0] canonical_form(input logic [KBITS-1:0] v);
    logic [KBITS-1:0] fwd;
    logic [KBITS-1:0] rev;
    fwd = least_rotation(v);
    rev = least_rotation(flip_strand(v));
    return (fwd < rev) ? fwd : rev;
  endfunction

  // Returns 1 and the two-bit code for a valid base, 0 otherwise.
  function automatic bit decode_base(input logic [7:0] ch, output logic [1:0] code);
    code = 2'd0;
    case (ch)
      ckh_tb_pkg::CHAR_A: code = 2'd0;
      ckh_tb_pkg::CHAR_C: code = 2'd1;
      ckh_tb_pkg::CHAR_G: code = 2'd2;
      ckh_tb_pkg::CHAR_T: code = 2'd3;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Works out the result of one accepted request and updates the predicted state.
  function automatic void predict_request(input logic op, input logic [7:0] ch,
                                          input logic fst,
                                          input logic [ckh_pkg::IDX_BITS-1:0] idx);
    kmer_result_t     r;
    logic [1:0]       code;
    logic [KBITS-1:0] canon;
    r = '0;
    if (op == ckh_tb_pkg::OP_READ) begin
      r.kmer_valid = 1'b1;
      r.index = idx;
      if (idx < SLOTS && kmer_tally.exists(idx)) begin
        r.count = ckh_pkg::OUT_COUNT_BITS'(kmer_tally[idx]);
      end
    end else begin
      // A new string clears everything before its own base is looked at.
      if (fst) begin
        window_q = '0;
        bases_held = 0;
        kmer_tally.delete();
      end
      if (!decode_base(ch, code)) begin
        r.bad = 1'b1;
      end else begin
        window_q = {window_q[KBITS-3:0], code};
        if (bases_held < KMER_LEN) bases_held++;
        if (bases_held == KMER_LEN) begin
          canon = canonical_form(window_q);
          if (!kmer_tally.exists(canon)) kmer_tally[canon] = 0;
          if (kmer_tally[canon] < COUNT_TOP) kmer_tally[canon]++;
          r.kmer_valid = 1'b1;
          r.index = ckh_pkg::IDX_BITS'(canon);
          r.count = ckh_pkg::OUT_COUNT_BITS'(kmer_tally[canon]);
        end
      end
    end
    awaited_results.push_back(r);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  // Requests are predicted as they are accepted; results are checked in order.
  always @(posedge clk) begin : watch
    kmer_result_t due;
    if (rst) begin
      awaited_results.delete();
      window_q = '0;
      bases_held = 0;
      kmer_tally.delete();
      errs = 0;
    end else begin
      if (in_valid && !in_stall) predict_request(operation, base_char, first, read_index);
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("Result arrived with no request outstanding");
          errs++;
        end else begin
          due = awaited_results.pop_front();
          compare_field("kmer_valid", 32'(due.kmer_valid), 32'(kmer_valid));
          compare_field("canonical_index", 32'(due.index), 32'(canonical_index));
          compare_field("count", 32'(due.count), 32'(count));
          compare_field("bad_char", 32'(due.bad), 32'(bad_char));
        end
      end
    end
    error_count <= errs;
    pending_results <= awaited_results.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the canonical k-mer histogram testbench: clock, reset, request and result traffic, verdict.
// Depends on ckh_pkg, ckh_tb_pkg, kmer_tally_checker and canonical_kmer_histogram_unit.
module tb_top;

  localparam int TARGET_REQUESTS = 1400;
  localparam int TARGET_STRINGS  = 300;
  localparam int HOLD_OFF_CYCLES = 80;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  logic                               operation;
  logic [ckh_pkg::CHAR_BITS-1:0]      base_char;
  logic                               first;
  logic [ckh_pkg::IDX_BITS-1:0]       read_index;
  logic                               out_valid;
  logic                               out_stall;
  logic                               kmer_valid;
  logic [ckh_pkg::IDX_BITS-1:0]       canonical_index;
  logic [ckh_pkg::OUT_COUNT_BITS-1:0] count;
  logic                               bad_char;
  int                                 error_count;
  int                                 pending_results;

  // Traffic shaping shared by the request and result sides.
  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  bit hold_req       = 1'b0;

  int requests_sent   = 0;
  int reads_sent      = 0;
  int strings_started = 0;
  int bad_sent        = 0;

  canonical_kmer_histogram_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .base_char       (base_char),
    .first           (first),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kmer_valid      (kmer_valid),
    .canonical_index (canonical_index),
    .count           (count),
    .bad_char        (bad_char)
  );

  kmer_tally_checker u_tally (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .base_char       (base_char),
    .first           (first),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kmer_valid      (kmer_valid),
    .canonical_index (canonical_index),
    .count           (count),
    .bad_char        (bad_char),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic offer(input logic op, input logic [7:0] ch, input logic fst,
                       input logic [ckh_pkg::IDX_BITS-1:0] idx);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    base_char  <= ch;
    first      <= fst;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (op == ckh_tb_pkg::OP_READ) begin
      reads_sent++;
    end else begin
      if (fst) strings_started++;
      if (!(ch inside {ckh_tb_pkg::CHAR_A, ckh_tb_pkg::CHAR_C,
                       ckh_tb_pkg::CHAR_G, ckh_tb_pkg::CHAR_T})) bad_sent++;
    end
  endtask

  // A push carries a random, ignored read index.
  task automatic push_base(input logic [7:0] ch, input logic fst);
    offer(ckh_tb_pkg::OP_PUSH, ch, fst, ckh_pkg::IDX_BITS'($urandom_range(0, 4095)));
  endtask

  // A read carries random, ignored character and new-string bits.
  task automatic read_count(input logic [ckh_pkg::IDX_BITS-1:0] idx);
    offer(ckh_tb_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  // Canonical values tend to be small, so most reads look there.
  function automatic logic [ckh_pkg::IDX_BITS-1:0] random_index();
    if ($urandom_range(0, 9) < 7) return ckh_pkg::IDX_BITS'($urandom_range(0, 127));
    return ckh_pkg::IDX_BITS'($urandom_range(0, 4095));
  endfunction

  // Mostly valid bases; a narrow string uses only A and C so that k-mers repeat.
  function automatic logic [7:0] random_char(input bit narrow);
    logic [7:0] bases [4];
    bases = '{ckh_tb_pkg::CHAR_A, ckh_tb_pkg::CHAR_C, ckh_tb_pkg::CHAR_G, ckh_tb_pkg::CHAR_T};
    if ($urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
    return bases[2'(narrow ? $urandom_range(0, 1) : $urandom_range(0, 3))];
  endfunction

  // Sender pause until the block has answered every request.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Request stimulus and verdict.
  initial begin : stimulus
    bit narrow;
    bit hold_done;
    int extra;
    hold_done = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= ckh_tb_pkg::OP_PUSH;
    base_char  <= '0;
    first      <= 1'b0;
    read_index <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads of an empty table, the new-string bit on a read, bad characters,
    // a window filling up, repeats of one canonical k-mer, a non-canonical read,
    // and a new string clearing the counts.
    offer(ckh_tb_pkg::OP_READ, 8'h00, 1'b1, ckh_pkg::IDX_BITS'(0));
    offer(ckh_tb_pkg::OP_READ, 8'hFF, 1'b0, '1);
    push_base(8'hFF, 1'b1);
    push_base(8'h00, 1'b0);
    repeat (5) push_base(ckh_tb_pkg::CHAR_A, 1'b0);
    push_base(ckh_tb_pkg::CHAR_A, 1'b0);
    push_base(ckh_tb_pkg::CHAR_A, 1'b0);
    repeat (6) push_base(ckh_tb_pkg::CHAR_T, 1'b0);
    push_base(ckh_tb_pkg::CHAR_C, 1'b0);
    push_base(8'h80, 1'b0);
    push_base(ckh_tb_pkg::CHAR_G, 1'b0);
    push_base(ckh_tb_pkg::CHAR_G, 1'b0);
    read_count(ckh_pkg::IDX_BITS'(0));
    read_count('1);
    read_count(ckh_pkg::IDX_BITS'(1));
    push_base(ckh_tb_pkg::CHAR_G, 1'b1);
    read_count(ckh_pkg::IDX_BITS'(0));
    wait_drained();

    // Random strings: a new-string push, then either a few bases or a long run,
    // with reads mixed in.
    while (requests_sent < TARGET_REQUESTS) begin
      if (!hold_req && $urandom_range(0, 11) == 0) begin
        sender_quiet   = $urandom_range(0, 2) == 0;
        receiver_quiet = $urandom_range(0, 2) == 0;
      end
      if (!hold_done && requests_sent > 500) begin
        hold_done    = 1'b1;
        sender_quiet = 1'b1;
        hold_req     = 1'b1;
      end
      if (strings_started % 60 == 59) wait_drained();
      narrow = $urandom_range(0, 2) == 0;
      extra = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(5, 16);
      push_base(random_char(narrow), 1'b1);
      repeat (extra) begin
        if ($urandom_range(0, 99) < 15) read_count(random_index());
        push_base(random_char(narrow), 1'b0);
      end
      if ($urandom_range(0, 1)) read_count(random_index());
    end

    // Short strings until the table's clearing mark has wrapped, then a check after it.
    sender_quiet = 1'b0;
    while (strings_started < TARGET_STRINGS) push_base(random_char(1'b0), 1'b1);
    read_count(ckh_pkg::IDX_BITS'(0));
    repeat (10) push_base(random_char(1'b1), 1'b0);
    repeat (4) read_count(random_index());

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d requests: %0d reads, %0d new strings, %0d bad characters.",
             requests_sent, reads_sent, strings_started, bad_sent);
    $display("It included a %0d-cycle result hold-off and several drain pauses.",
             HOLD_OFF_CYCLES);
    if (error_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls per result, one long hold-off on request.
  initial begin : result_taker
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        hold = receiver_quiet ? 0 : $urandom_range(0, 6);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
